// File: rtl/tsvenc_pkg.sv
// shared types and constants for the tag run splitter and varint packer
package tsvenc_pkg;

  localparam int NODE_ID_BITS  = 29;
  localparam int POSITION_BITS = 48;
  localparam int OFFSET_BITS   = 10;
  localparam int RUN_LEN_BITS  = 16;
  localparam int LEN_SHIFT     = OFFSET_BITS + 1;
  localparam int LEN_BITS_MIN  = 11;
  localparam int LEN_BITS_MAX  = 16;
  localparam int WORD_W        = LEN_SHIFT + LEN_BITS_MAX + NODE_ID_BITS;
  localparam int CODE_W        = 64;
  localparam int COUNT_W       = 4;
  localparam int SAMPLE_W      = 16;
  localparam int LEN_CFG_W     = 5;

  // configuration register indexes
  localparam logic CFG_LEN_FIELD_BITS = 1'b0;
  localparam logic CFG_SAMPLE_INTERVAL = 1'b1;

  typedef struct packed {
    logic [28:0] node_id;
    logic        reverse_flag;
    logic [9:0]  node_offset;
    logic [15:0] tag_len;
  } tsv_in_t;

  typedef struct packed {
    logic [63:0] code_bytes;
    logic [3:0]  byte_count;
    logic [47:0] start_pos;
    logic        sample_mark;
    logic [47:0] sample_byte_position;
    logic        last_of_run;
  } tsv_out_t;

  // status of the varint shifter back to the sequencer
  typedef struct packed {
    logic               done;
    logic [COUNT_W-1:0] count;
  } vint_stat_t;

endpackage

// File: rtl/tsvenc_varint.sv
// iterative varint packer: one 7-bit group per cycle off a shift register
module tsvenc_varint
  import tsvenc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] word,
  output vint_stat_t        stat,
  output logic [CODE_W-1:0] code
);

  logic               busy_r;
  logic               done_r;
  logic [WORD_W-1:0]  word_r;
  logic [CODE_W-1:0]  code_r;
  logic [2:0]         idx_r;
  logic [COUNT_W-1:0] cnt_r;
  logic               more;

  // another byte follows while bits remain above the low seven
  assign more = (|word_r[WORD_W-1:7]) && (idx_r != 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && !more) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      word_r <= word;
      code_r <= '0;
      idx_r  <= 3'd0;
    end else if (busy_r) begin
      if (more) begin
        code_r[{idx_r, 3'b000} +: 8] <= {1'b1, word_r[6:0]};
        word_r <= word_r >> 7;
        idx_r  <= idx_r + 3'd1;
      end else begin
        code_r[{idx_r, 3'b000} +: 8] <= word_r[7:0];
        cnt_r <= {1'b0, idx_r} + 4'd1;
      end
    end
  end

  assign stat.done  = done_r;
  assign stat.count = cnt_r;
  assign code       = code_r;

endmodule

// File: rtl/tag_run_split_pack_varint_encoder.sv
// Tag run splitter and varint packer. Each accepted run is cut into chunks of
// at most 2^L-1 positions, each chunk is packed into a word and sent out as a
// little-endian base-128 varint with its running position and, on every k-th
// chunk, the running byte position. One run at a time: the input stalls from
// acceptance until its last chunk has been loaded into the output register.
// Each chunk passes the split, encode and emit states; encode waits on the
// varint shifter, which moves out one 7-bit group per cycle. A zero-length
// run is accepted without leaving idle and gives no result.
module tag_run_split_pack_varint_encoder
  import tsvenc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tsv_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tsv_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SPLIT = 2'd1;
  localparam logic [1:0] S_ENC   = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic [LEN_CFG_W-1:0]     len_cfg_r;
  logic [SAMPLE_W-1:0]      interval_r;
  logic [POSITION_BITS-1:0] pos_r;
  logic [POSITION_BITS-1:0] bytes_r;
  logic [SAMPLE_W-1:0]      cus_r;

  logic [NODE_ID_BITS-1:0]  node_r;
  logic                     flag_r;
  logic [OFFSET_BITS-1:0]   offset_r;
  logic [RUN_LEN_BITS-1:0]  remaining_r;
  logic [LEN_CFG_W-1:0]     lb_r;
  logic [RUN_LEN_BITS-1:0]  chunk_len_r;
  logic                     last_r;

  logic                     out_valid_r;
  tsv_out_t                 out_data_r;

  logic                     in_acc;
  logic                     slot_free;
  logic [LEN_CFG_W-1:0]     lb_eff;
  logic [RUN_LEN_BITS:0]    full;
  logic                     is_full;
  logic [RUN_LEN_BITS-1:0]  chunk_len;
  logic [5:0]               node_shift;
  logic [WORD_W-1:0]        word;
  logic                     vint_start;
  vint_stat_t               vstat;
  logic [CODE_W-1:0]        vcode;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // clamp the length field width to its legal range
  always_comb begin
    if (len_cfg_r < LEN_CFG_W'(LEN_BITS_MIN)) begin
      lb_eff = LEN_CFG_W'(LEN_BITS_MIN);
    end else if (len_cfg_r > LEN_CFG_W'(LEN_BITS_MAX)) begin
      lb_eff = LEN_CFG_W'(LEN_BITS_MAX);
    end else begin
      lb_eff = len_cfg_r;
    end
  end

  assign full       = (RUN_LEN_BITS+1)'(1) << lb_r;
  assign is_full    = {1'b0, remaining_r} >= full;
  assign chunk_len  = is_full ? RUN_LEN_BITS'(full - (RUN_LEN_BITS+1)'(1)) : remaining_r;
  assign node_shift = 6'(LEN_SHIFT) + {1'b0, lb_r};
  assign word       = WORD_W'(offset_r)
                    | (WORD_W'(flag_r) << OFFSET_BITS)
                    | (WORD_W'(chunk_len) << LEN_SHIFT)
                    | (WORD_W'(node_r) << node_shift);
  assign vint_start = (state_r == S_SPLIT);

  tsvenc_varint u_varint (
    .clk   (clk),
    .rst_n (rst_n),
    .start (vint_start),
    .word  (word),
    .stat  (vstat),
    .code  (vcode)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_data.tag_len != '0)) state_nxt = S_SPLIT;
      end
      S_SPLIT: state_nxt = S_ENC;
      S_ENC: begin
        if (vstat.done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) state_nxt = last_r ? S_IDLE : S_SPLIT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_cfg_r   <= LEN_CFG_W'(LEN_BITS_MIN);
      interval_r  <= SAMPLE_W'(16);
      pos_r       <= '0;
      bytes_r     <= '0;
      cus_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_LEN_FIELD_BITS:  len_cfg_r  <= cfg_data[LEN_CFG_W-1:0];
          CFG_SAMPLE_INTERVAL: interval_r <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
        pos_r   <= pos_r + POSITION_BITS'(chunk_len_r);
        bytes_r <= bytes_r + POSITION_BITS'(vstat.count);
        // countdown reloads on a sampled chunk, zero interval acts as one
        if (cus_r == '0) begin
          cus_r <= (interval_r == '0) ? '0 : interval_r - SAMPLE_W'(1);
        end else begin
          cus_r <= cus_r - SAMPLE_W'(1);
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      node_r      <= in_data.node_id[NODE_ID_BITS-1:0];
      flag_r      <= in_data.reverse_flag;
      offset_r    <= in_data.node_offset;
      remaining_r <= in_data.tag_len;
      lb_r        <= lb_eff;
    end else if (state_r == S_SPLIT) begin
      chunk_len_r <= chunk_len;
      last_r      <= !is_full;
      remaining_r <= is_full ? remaining_r - chunk_len : '0;
    end
    if (state_r == S_EMIT && slot_free) begin
      out_data_r.code_bytes           <= vcode;
      out_data_r.byte_count           <= vstat.count;
      out_data_r.start_pos            <= pos_r;
      out_data_r.sample_mark          <= (cus_r == '0);
      out_data_r.sample_byte_position <= (cus_r == '0) ? bytes_r : '0;
      out_data_r.last_of_run          <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_done_in_enc: assert property (@(posedge clk) disable iff (!rst_n)
    vstat.done |-> (state_r == S_ENC))
    else $error("varint done outside encode state");

  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_SPLIT || state_r == S_IDLE))
    else $error("bad state after run accepted");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.byte_count != 4'd0 && out_data_r.byte_count <= 4'd8))
    else $error("byte count out of range");

  a_sample_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.sample_mark) |-> (out_data_r.sample_byte_position == '0))
    else $error("byte position set on unsampled chunk");
`endif

endmodule
